// ----- rtl/bvs_pkg.sv -----
package bvs_pkg;

    // Default number of fraction bits of the velocity scale
    localparam int BVS_SCALE_FRAC_BITS = 16;

    // Field widths
    localparam int DIST_W  = 23;
    localparam int CLR_W   = 24;
    localparam int SPEED_W = 23;
    localparam int RATE_W  = 24;
    localparam int LAT_W   = 20;
    localparam int DECEL_W = 27;

    // Register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SLOW_DISTANCE = 2'd0;
    localparam logic [1:0] REG_HARD_FLOOR    = 2'd1;
    localparam logic [1:0] REG_LATENCY       = 2'd2;
    localparam logic [1:0] REG_BRAKE_DECEL   = 2'd3;

    localparam logic [DIST_W-1:0]  SLOW_DISTANCE_RST = DIST_W'(100000);
    localparam logic [DIST_W-1:0]  HARD_FLOOR_RST    = DIST_W'(20000);
    localparam logic [LAT_W-1:0]   LATENCY_RST       = LAT_W'(10000);
    localparam logic [DECEL_W-1:0] BRAKE_DECEL_RST   = DECEL_W'(2000000);

    // Thresholds of the special cases
    localparam logic signed [RATE_W-1:0] RETREAT_EPS_UM_S = RATE_W'(100);
    localparam logic [SPEED_W-1:0]       CLOSING_EPS_UM_S = SPEED_W'(1);

    // Latency travel: ceil(speed * latency / 1e6) by reciprocal multiply
    localparam int             US_PER_S       = 1000000;
    localparam int             TRAVEL_PROD_W  = SPEED_W + LAT_W;
    localparam int             TRAVEL_NUM_W   = TRAVEL_PROD_W + 1;
    localparam int             TRAVEL_HALF_W  = TRAVEL_NUM_W / 2;
    localparam int             RECIP_SHIFT    = TRAVEL_NUM_W;
    localparam int             RECIP_W        = 25;
    localparam longint         RECIP_US_L     = (64'd1 << RECIP_SHIFT) / US_PER_S;
    localparam logic [RECIP_W-1:0] RECIP_US   = RECIP_W'(RECIP_US_L);
    localparam int             TRAVEL_PP_W    = TRAVEL_HALF_W + RECIP_W;
    localparam int             TRAVEL_SUM_W   = TRAVEL_PP_W + TRAVEL_HALF_W;
    localparam int             TRAVEL_W       = 24;

    // Effective clearance and braking product
    localparam int DEFF_W = 27;
    localparam int XH_W   = DECEL_W + DIST_W;
    localparam int VSQ_W  = 2 * SPEED_W;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_CALC
    } bvs_kind_t;

    typedef struct packed {
        logic [DIST_W-1:0]  slow_distance_um;
        logic [DIST_W-1:0]  hard_floor_um;
        logic [LAT_W-1:0]   latency_us;
        logic [DECEL_W-1:0] brake_decel_um_s2;
    } bvs_cfg_t;

    typedef struct packed {
        logic                     verdict_valid;
        logic                     inside_hard_floor;
        logic signed [CLR_W-1:0]  min_clearance_um;
        logic [SPEED_W-1:0]       closing_speed_um_s;
        logic signed [RATE_W-1:0] clearance_rate_um_s;
    } bvs_item_t;

endpackage

// ----- rtl/bvs_if.sv -----
interface bvs_in_if;
    import bvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     verdict_valid;
    logic                     inside_hard_floor;
    logic signed [CLR_W-1:0]  min_clearance_um;
    logic [SPEED_W-1:0]       closing_speed_um_s;
    logic signed [RATE_W-1:0] clearance_rate_um_s;

    modport source (
        output valid, verdict_valid, inside_hard_floor, min_clearance_um,
               closing_speed_um_s, clearance_rate_um_s,
        input  ready
    );

    modport sink (
        input  valid, verdict_valid, inside_hard_floor, min_clearance_um,
               closing_speed_um_s, clearance_rate_um_s,
        output ready
    );
endinterface

interface bvs_out_if #(
    parameter int FRAC_BITS = bvs_pkg::BVS_SCALE_FRAC_BITS
);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   velocity_scale_q16;

    modport source (
        output valid, velocity_scale_q16,
        input  ready
    );

    modport sink (
        input  valid, velocity_scale_q16,
        output ready
    );
endinterface

// ----- rtl/bvs_core.sv -----
module bvs_core #(
    parameter int SCALE_FRAC_BITS = bvs_pkg::BVS_SCALE_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       item_valid,
    input  bvs_pkg::bvs_item_t         item,
    input  bvs_pkg::bvs_cfg_t          cfg,
    output logic                       result_valid,
    output logic [SCALE_FRAC_BITS:0]   result
);
    import bvs_pkg::*;

    localparam int F     = SCALE_FRAC_BITS;
    localparam int RW    = SPEED_W + F;
    localparam int TW    = 2 * RW;
    localparam int REM_W = RW + 2;

    // ------------------------------------------------------------------
    // Stage 1: classify the verdict, start the latency and speed products
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    bvs_kind_t                 s1_kind_reg, s1_kind_next;
    logic signed [CLR_W-1:0]   s1_d_reg;
    logic [SPEED_W-1:0]        s1_vc_reg;
    logic [TRAVEL_PROD_W-1:0]  s1_p_reg, s1_p_next;
    logic [VSQ_W-1:0]          s1_vsq_reg, s1_vsq_next;

    always_comb
    begin
        s1_kind_next = KIND_CALC;
        if (!item.verdict_valid)
        begin
            s1_kind_next = KIND_ZERO;
        end
        else if (item.inside_hard_floor)
        begin
            s1_kind_next = (item.clearance_rate_um_s > RETREAT_EPS_UM_S) ? KIND_FULL
                                                                         : KIND_ZERO;
        end
        else if (item.min_clearance_um > $signed({1'b0, cfg.slow_distance_um}))
        begin
            s1_kind_next = KIND_FULL;
        end
        else if (item.closing_speed_um_s <= CLOSING_EPS_UM_S)
        begin
            s1_kind_next = KIND_FULL;
        end
    end

    assign s1_p_next   = TRAVEL_PROD_W'(item.closing_speed_um_s) * TRAVEL_PROD_W'(cfg.latency_us);
    assign s1_vsq_next = VSQ_W'(item.closing_speed_um_s) * VSQ_W'(item.closing_speed_um_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_d_reg    <= item.min_clearance_um;
            s1_vc_reg   <= item.closing_speed_um_s;
            s1_p_reg    <= s1_p_next;
            s1_vsq_reg  <= s1_vsq_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: add the rounding term for the ceiling of the travel
    // ------------------------------------------------------------------
    logic                      s2_valid_reg;
    bvs_kind_t                 s2_kind_reg;
    logic signed [CLR_W-1:0]   s2_d_reg;
    logic [SPEED_W-1:0]        s2_vc_reg;
    logic [VSQ_W-1:0]          s2_vsq_reg;
    logic [TRAVEL_NUM_W-1:0]   s2_n_reg, s2_n_next;

    assign s2_n_next = TRAVEL_NUM_W'(s1_p_reg) + TRAVEL_NUM_W'(US_PER_S - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_d_reg    <= s1_d_reg;
            s2_vc_reg   <= s1_vc_reg;
            s2_vsq_reg  <= s1_vsq_reg;
            s2_n_reg    <= s2_n_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal multiply, split into two partial products
    // ------------------------------------------------------------------
    logic                      s3_valid_reg;
    bvs_kind_t                 s3_kind_reg;
    logic signed [CLR_W-1:0]   s3_d_reg;
    logic [SPEED_W-1:0]        s3_vc_reg;
    logic [VSQ_W-1:0]          s3_vsq_reg;
    logic [TRAVEL_NUM_W-1:0]   s3_n_reg;
    logic [TRAVEL_PP_W-1:0]    s3_lo_reg, s3_lo_next;
    logic [TRAVEL_PP_W-1:0]    s3_hi_reg, s3_hi_next;

    assign s3_lo_next = TRAVEL_PP_W'(s2_n_reg[TRAVEL_HALF_W-1:0]) * TRAVEL_PP_W'(RECIP_US);
    assign s3_hi_next = TRAVEL_PP_W'(s2_n_reg[TRAVEL_NUM_W-1:TRAVEL_HALF_W])
                        * TRAVEL_PP_W'(RECIP_US);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_d_reg    <= s2_d_reg;
            s3_vc_reg   <= s2_vc_reg;
            s3_vsq_reg  <= s2_vsq_reg;
            s3_n_reg    <= s2_n_reg;
            s3_lo_reg   <= s3_lo_next;
            s3_hi_reg   <= s3_hi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: combine partial products, estimate is exact or one low
    // ------------------------------------------------------------------
    logic                      s4_valid_reg;
    bvs_kind_t                 s4_kind_reg;
    logic signed [CLR_W-1:0]   s4_d_reg;
    logic [SPEED_W-1:0]        s4_vc_reg;
    logic [VSQ_W-1:0]          s4_vsq_reg;
    logic [TRAVEL_NUM_W-1:0]   s4_n_reg;
    logic [TRAVEL_W-1:0]       s4_qe_reg, s4_qe_next;
    logic [TRAVEL_SUM_W-1:0]   s4_sum;

    assign s4_sum     = TRAVEL_SUM_W'(s3_lo_reg) + (TRAVEL_SUM_W'(s3_hi_reg) << TRAVEL_HALF_W);
    assign s4_qe_next = s4_sum[RECIP_SHIFT +: TRAVEL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_d_reg    <= s3_d_reg;
            s4_vc_reg   <= s3_vc_reg;
            s4_vsq_reg  <= s3_vsq_reg;
            s4_n_reg    <= s3_n_reg;
            s4_qe_reg   <= s4_qe_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: multiply the estimate back by one million
    // ------------------------------------------------------------------
    logic                      s5_valid_reg;
    bvs_kind_t                 s5_kind_reg;
    logic signed [CLR_W-1:0]   s5_d_reg;
    logic [SPEED_W-1:0]        s5_vc_reg;
    logic [VSQ_W-1:0]          s5_vsq_reg;
    logic [TRAVEL_NUM_W-1:0]   s5_n_reg;
    logic [TRAVEL_W-1:0]       s5_qe_reg;
    logic [TRAVEL_NUM_W-1:0]   s5_qm_reg, s5_qm_next;

    assign s5_qm_next = TRAVEL_NUM_W'(s4_qe_reg) * TRAVEL_NUM_W'(US_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_kind_reg <= s4_kind_reg;
            s5_d_reg    <= s4_d_reg;
            s5_vc_reg   <= s4_vc_reg;
            s5_vsq_reg  <= s4_vsq_reg;
            s5_n_reg    <= s4_n_reg;
            s5_qe_reg   <= s4_qe_reg;
            s5_qm_reg   <= s5_qm_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: correct the travel estimate by one where the remainder allows
    // ------------------------------------------------------------------
    logic                      s6_valid_reg;
    bvs_kind_t                 s6_kind_reg;
    logic signed [CLR_W-1:0]   s6_d_reg;
    logic [SPEED_W-1:0]        s6_vc_reg;
    logic [VSQ_W-1:0]          s6_vsq_reg;
    logic [TRAVEL_W-1:0]       s6_travel_reg, s6_travel_next;
    logic [TRAVEL_NUM_W-1:0]   s6_rem;

    assign s6_rem         = s5_n_reg - s5_qm_reg;
    assign s6_travel_next = s5_qe_reg
                            + TRAVEL_W'(s6_rem >= TRAVEL_NUM_W'(US_PER_S));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_kind_reg   <= s5_kind_reg;
            s6_d_reg      <= s5_d_reg;
            s6_vc_reg     <= s5_vc_reg;
            s6_vsq_reg    <= s5_vsq_reg;
            s6_travel_reg <= s6_travel_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: effective clearance, drop to zero when no room is left
    // ------------------------------------------------------------------
    logic                      s7_valid_reg;
    bvs_kind_t                 s7_kind_reg, s7_kind_next;
    logic [SPEED_W-1:0]        s7_vc_reg;
    logic [VSQ_W-1:0]          s7_vsq_reg;
    logic [DIST_W-1:0]         s7_deff_reg;
    logic signed [DEFF_W-1:0]  s7_deff;

    assign s7_deff = $signed({{(DEFF_W-CLR_W){s6_d_reg[CLR_W-1]}}, s6_d_reg})
                     - $signed({{(DEFF_W-DIST_W){1'b0}}, cfg.hard_floor_um})
                     - $signed({{(DEFF_W-TRAVEL_W){1'b0}}, s6_travel_reg});

    always_comb
    begin
        s7_kind_next = s6_kind_reg;
        if (s6_kind_reg == KIND_CALC && (s7_deff[DEFF_W-1] || s7_deff == '0))
        begin
            s7_kind_next = KIND_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s7_kind_reg <= s7_kind_next;
            s7_vc_reg   <= s6_vc_reg;
            s7_vsq_reg  <= s6_vsq_reg;
            s7_deff_reg <= s7_deff[DIST_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: deceleration times effective clearance
    // ------------------------------------------------------------------
    logic                      s8_valid_reg;
    bvs_kind_t                 s8_kind_reg;
    logic [SPEED_W-1:0]        s8_vc_reg;
    logic [VSQ_W-1:0]          s8_vsq_reg;
    logic [XH_W-1:0]           s8_xh_reg, s8_xh_next;

    assign s8_xh_next = XH_W'(cfg.brake_decel_um_s2) * XH_W'(s7_deff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s8_kind_reg <= s7_kind_reg;
            s8_vc_reg   <= s7_vc_reg;
            s8_vsq_reg  <= s7_vsq_reg;
            s8_xh_reg   <= s8_xh_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: full speed when the stopping speed covers the closing speed
    // ------------------------------------------------------------------
    logic                      s9_valid_reg;
    bvs_kind_t                 s9_kind_reg, s9_kind_next;
    logic [SPEED_W-1:0]        s9_vc_reg;
    logic [VSQ_W-1:0]          s9_x_reg;
    logic [XH_W:0]             s9_x2;

    assign s9_x2 = {s8_xh_reg, 1'b0};

    always_comb
    begin
        s9_kind_next = s8_kind_reg;
        if (s8_kind_reg == KIND_CALC && s9_x2 >= (XH_W+1)'(s8_vsq_reg))
        begin
            s9_kind_next = KIND_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s9_kind_reg <= s9_kind_next;
            s9_vc_reg   <= s8_vc_reg;
            s9_x_reg    <= s9_x2[VSQ_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Square root of x * 2^(2F), one root bit per stage
    // ------------------------------------------------------------------
    logic               sq_valid_reg [RW];
    bvs_kind_t          sq_kind_reg  [RW];
    logic [SPEED_W-1:0] sq_vc_reg    [RW];
    logic [RW-1:0]      sq_root_reg  [RW];
    logic [REM_W-1:0]   sq_rem_reg   [RW];
    logic [TW-1:0]      sq_t_reg     [RW];

    logic               sq_valid_in  [RW];
    bvs_kind_t          sq_kind_in   [RW];
    logic [SPEED_W-1:0] sq_vc_in     [RW];
    logic [RW-1:0]      sq_root_in   [RW];
    logic [REM_W-1:0]   sq_rem_in    [RW];
    logic [TW-1:0]      sq_t_in      [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_sqrt
            logic [REM_W+1:0] rem_sh;
            logic [REM_W+1:0] trial;
            logic             take;
            logic [REM_W-1:0] rem_next;
            logic [RW-1:0]    root_next;

            if (k == 0)
            begin : g_first
                assign sq_valid_in[k] = s9_valid_reg;
                assign sq_kind_in[k]  = s9_kind_reg;
                assign sq_vc_in[k]    = s9_vc_reg;
                assign sq_root_in[k]  = '0;
                assign sq_rem_in[k]   = '0;
                assign sq_t_in[k]     = {s9_x_reg, {(2*F){1'b0}}};
            end
            else
            begin : g_next
                assign sq_valid_in[k] = sq_valid_reg[k-1];
                assign sq_kind_in[k]  = sq_kind_reg[k-1];
                assign sq_vc_in[k]    = sq_vc_reg[k-1];
                assign sq_root_in[k]  = sq_root_reg[k-1];
                assign sq_rem_in[k]   = sq_rem_reg[k-1];
                assign sq_t_in[k]     = sq_t_reg[k-1];
            end

            // Bring down the next bit pair and try a one root bit
            assign rem_sh    = {sq_rem_in[k], sq_t_in[k][TW-1 -: 2]};
            assign trial     = (REM_W+2)'({sq_root_in[k], 2'b01});
            assign take      = rem_sh >= trial;
            assign rem_next  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            assign root_next = {sq_root_in[k][RW-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_valid_reg[k] <= 1'b0;
                end
                else if (advance)
                begin
                    sq_valid_reg[k] <= sq_valid_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    sq_kind_reg[k] <= sq_kind_in[k];
                    sq_vc_reg[k]   <= sq_vc_in[k];
                    sq_root_reg[k] <= root_next;
                    sq_rem_reg[k]  <= rem_next;
                    sq_t_reg[k]    <= sq_t_in[k] << 2;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Root over closing speed, one quotient bit per stage
    // ------------------------------------------------------------------
    logic               dv_valid_reg [F];
    bvs_kind_t          dv_kind_reg  [F];
    logic [SPEED_W-1:0] dv_vc_reg    [F];
    logic [SPEED_W-1:0] dv_r_reg     [F];
    logic [F-1:0]       dv_lo_reg    [F];
    logic [F-1:0]       dv_q_reg     [F];

    logic               dv_valid_in  [F];
    bvs_kind_t          dv_kind_in   [F];
    logic [SPEED_W-1:0] dv_vc_in     [F];
    logic [SPEED_W-1:0] dv_r_in      [F];
    logic [F-1:0]       dv_lo_in     [F];
    logic [F-1:0]       dv_q_in      [F];

    genvar j;
    generate
        for (j = 0; j < F; j++)
        begin : g_div
            logic [SPEED_W:0]   r_sh;
            logic               take;
            logic [SPEED_W-1:0] r_next;

            if (j == 0)
            begin : g_first
                // The root's upper part is below the speed, so it seeds the remainder
                assign dv_valid_in[j] = sq_valid_reg[RW-1];
                assign dv_kind_in[j]  = sq_kind_reg[RW-1];
                assign dv_vc_in[j]    = sq_vc_reg[RW-1];
                assign dv_r_in[j]     = sq_root_reg[RW-1][RW-1:F];
                assign dv_lo_in[j]    = sq_root_reg[RW-1][F-1:0];
                assign dv_q_in[j]     = '0;
            end
            else
            begin : g_next
                assign dv_valid_in[j] = dv_valid_reg[j-1];
                assign dv_kind_in[j]  = dv_kind_reg[j-1];
                assign dv_vc_in[j]    = dv_vc_reg[j-1];
                assign dv_r_in[j]     = dv_r_reg[j-1];
                assign dv_lo_in[j]    = dv_lo_reg[j-1];
                assign dv_q_in[j]     = dv_q_reg[j-1];
            end

            // Shift in the next root bit and subtract the speed where it fits
            assign r_sh   = {dv_r_in[j], dv_lo_in[j][F-1]};
            assign take   = r_sh >= {1'b0, dv_vc_in[j]};
            assign r_next = take ? SPEED_W'(r_sh - {1'b0, dv_vc_in[j]}) : SPEED_W'(r_sh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_valid_reg[j] <= 1'b0;
                end
                else if (advance)
                begin
                    dv_valid_reg[j] <= dv_valid_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    dv_kind_reg[j] <= dv_kind_in[j];
                    dv_vc_reg[j]   <= dv_vc_in[j];
                    dv_r_reg[j]    <= r_next;
                    dv_lo_reg[j]   <= dv_lo_in[j] << 1;
                    dv_q_reg[j]    <= {dv_q_in[j][F-2:0], take};
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Select the final scale
    // ------------------------------------------------------------------
    assign result_valid = dv_valid_reg[F-1];

    always_comb
    begin
        case (dv_kind_reg[F-1])
            KIND_FULL: result = (F+1)'(1) << F;
            KIND_CALC: result = {1'b0, dv_q_reg[F-1]};
            default:   result = '0;
        endcase
    end

endmodule

// ----- rtl/braking_velocity_scale.sv -----
// Velocity scale from one clearance verdict.
//
// Input channel (verdict): one beat per clearance verdict, taken when valid
// and ready are both high. Output channel (scale): one beat per verdict in
// the same order, velocity_scale_q16 with SCALE_FRAC_BITS fraction bits,
// 2^SCALE_FRAC_BITS meaning full speed.
// Registers sit on the APB-style port at byte addresses 0, 4, 8 and 12;
// write them only while no verdict is in flight.
//
// Throughput: one verdict per cycle while the output buffer has room. The
// pipeline is made of 9 arithmetic stages, one square-root stage per root
// bit (23 + SCALE_FRAC_BITS) and one divider stage per fraction bit.
// A two-entry output buffer decouples the pipeline from the receiver. When
// the receiver stalls, the buffer fills, then the whole pipeline freezes
// and ready drops until a beat leaves; nothing is dropped or repeated.
// Reset clears all valid bits and the buffer and loads the register
// defaults; the block takes verdicts in the first cycle after reset.
module braking_velocity_scale #(
    parameter int SCALE_FRAC_BITS = bvs_pkg::BVS_SCALE_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bvs_in_if.sink                      verdict,
    bvs_out_if.source                   scale,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bvs_pkg::ADDR_W-1:0]  paddr,
    input  logic [bvs_pkg::DATA_W-1:0]  pwdata,
    output logic [bvs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bvs_pkg::*;

    localparam int F = SCALE_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    bvs_cfg_t cfg_reg;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_distance_um  <= SLOW_DISTANCE_RST;
            cfg_reg.hard_floor_um     <= HARD_FLOOR_RST;
            cfg_reg.latency_us        <= LATENCY_RST;
            cfg_reg.brake_decel_um_s2 <= BRAKE_DECEL_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SLOW_DISTANCE: cfg_reg.slow_distance_um  <= pwdata[DIST_W-1:0];
                REG_HARD_FLOOR:    cfg_reg.hard_floor_um     <= pwdata[DIST_W-1:0];
                REG_LATENCY:       cfg_reg.latency_us        <= pwdata[LAT_W-1:0];
                REG_BRAKE_DECEL:   cfg_reg.brake_decel_um_s2 <= pwdata[DECEL_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SLOW_DISTANCE: prdata = DATA_W'(cfg_reg.slow_distance_um);
            REG_HARD_FLOOR:    prdata = DATA_W'(cfg_reg.hard_floor_um);
            REG_LATENCY:       prdata = DATA_W'(cfg_reg.latency_us);
            REG_BRAKE_DECEL:   prdata = DATA_W'(cfg_reg.brake_decel_um_s2);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------
    bvs_item_t     item;
    logic          advance;
    logic          core_valid;
    logic [F:0]    core_result;
    logic [1:0]    count_reg, count_next;

    assign item.verdict_valid       = verdict.verdict_valid;
    assign item.inside_hard_floor   = verdict.inside_hard_floor;
    assign item.min_clearance_um    = verdict.min_clearance_um;
    assign item.closing_speed_um_s  = verdict.closing_speed_um_s;
    assign item.clearance_rate_um_s = verdict.clearance_rate_um_s;

    // Advance whenever the output buffer has room
    assign advance       = (count_reg != 2'd2);
    assign verdict.ready = advance;

    bvs_core #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item_valid   (verdict.valid),
        .item         (item),
        .cfg          (cfg_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // ------------------------------------------------------------------
    // Two-entry output buffer
    // ------------------------------------------------------------------
    logic [F:0] head_reg;
    logic [F:0] tail_reg;
    logic       push;
    logic       pop;

    assign push = core_valid && advance;
    assign pop  = scale.valid && scale.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the oldest beat in the head, the next one in the tail
    always_ff @(posedge clk)
    begin
        if (push && (count_reg == 2'd0 || (pop && count_reg == 2'd1)))
        begin
            head_reg <= core_result;
        end
        else if (pop && count_reg == 2'd2)
        begin
            head_reg <= tail_reg;
        end
        if (push && !pop && count_reg == 2'd1)
        begin
            tail_reg <= core_result;
        end
    end

    assign scale.valid              = (count_reg != 2'd0);
    assign scale.velocity_scale_q16 = head_reg;

endmodule
